// File: src/signed_int_to_decimal_ascii_defines.svh
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_defines
// assertion macros shared by the decimal text converter
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

`ifndef SYNTHESIS
`define SID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SID_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SID_ASSERT(lbl, prop, msg)
`define SID_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: src/sid_pkg.sv
// ----------------------------------------------------------------------------
// sid_pkg
// types and constants shared by the decimal text converter modules
// ----------------------------------------------------------------------------
package sid_pkg;

  localparam logic [7:0] DIGIT_BASE = 8'h30;
  localparam logic [7:0] MINUS_CHAR = 8'h2D;

  typedef struct packed {
    logic load;
    logic step;
    logic shift;
    logic emit_sign;
  } sid_cmd_t;

  typedef struct packed {
    logic conv_last;
    logic top_zero;
    logic last_digit;
    logic neg;
  } sid_sts_t;

endpackage

// File: src/sid_datapath.sv
// ----------------------------------------------------------------------------
// sid_datapath
// magnitude, shift-add-3 binary to bcd conversion and character forming
// ----------------------------------------------------------------------------
module sid_datapath
  import sid_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic [VALUE_BITS-1:0] value,
  input  sid_cmd_t              cmd,
  output sid_sts_t              sts,
  output logic [7:0]            character,
  output logic                  last_char
);

  localparam int NDIG  = (VALUE_BITS * 302) / 1000 + 1;
  localparam int BCD_W = NDIG * 4;
  localparam int CNT_W = $clog2(VALUE_BITS + 1);
  localparam int DIG_W = $clog2(NDIG + 1);

  logic [VALUE_BITS-1:0] bin;
  logic [BCD_W-1:0]      bcd;
  logic                  neg;
  logic [CNT_W-1:0]      conv_cnt;
  logic [DIG_W-1:0]      dig_left;

  logic [VALUE_BITS-1:0] mag;
  logic [BCD_W-1:0]      bcd_adj;
  logic [3:0]            top_digit;

  assign mag = value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? (bcd[i*4 +: 4] + 4'd3) : bcd[i*4 +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin      <= mag;
      bcd      <= '0;
      neg      <= value[VALUE_BITS-1];
      conv_cnt <= CNT_W'(VALUE_BITS);
      dig_left <= DIG_W'(NDIG);
    end else if (cmd.step) begin
      {bcd, bin} <= {bcd_adj[BCD_W-2:0], bin, 1'b0};
      conv_cnt   <= conv_cnt - CNT_W'(1);
    end else if (cmd.shift) begin
      bcd      <= {bcd[BCD_W-5:0], 4'h0};
      dig_left <= dig_left - DIG_W'(1);
    end
  end

  assign top_digit = bcd[BCD_W-1 -: 4];

  assign sts.conv_last  = (conv_cnt == CNT_W'(1));
  assign sts.top_zero   = (top_digit == 4'h0);
  assign sts.last_digit = (dig_left == DIG_W'(1));
  assign sts.neg        = neg;

  assign character = cmd.emit_sign ? MINUS_CHAR : (DIGIT_BASE | {4'h0, top_digit});
  assign last_char = !cmd.emit_sign && sts.last_digit;

endmodule

// File: src/sid_ctrl.sv
// ----------------------------------------------------------------------------
// sid_ctrl
// sequencer: accept, convert, drop leading zeros, send sign and digits
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_defines.svh"

module sid_ctrl
  import sid_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  sid_sts_t sts,
  output sid_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_SKIP = 5'b00100,
    ST_SIGN = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.step = 1'b1;
        if (sts.conv_last) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (sts.top_zero && !sts.last_digit) begin
          cmd.shift = 1'b1;
        end else begin
          state_next = sts.neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        out_valid     = 1'b1;
        cmd.emit_sign = 1'b1;
        if (out_ready) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.shift = 1'b1;
          if (sts.last_digit) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // input and output sides never open together
  `SID_ASSERT_ALWAYS(a_no_overlap, !(in_ready && out_valid), "ready and valid both high")
  `SID_ASSERT(a_load_conv, (in_valid && in_ready) |=> (state == ST_CONV), "no conversion after load")
  `SID_ASSERT(a_last_idle, (state == ST_EMIT && out_ready && sts.last_digit) |=> (state == ST_IDLE),
              "not idle after last item")
  `SID_ASSERT(a_sign_neg, (state == ST_SIGN) |-> sts.neg, "sign sent for non-negative value")

endmodule

// File: src/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// signed integer to decimal ascii text, one character per output item
// ----------------------------------------------------------------------------
// channel  handshake              payload
// in       in_valid / in_ready    value [VALUE_BITS-1:0] signed
// out      out_valid / out_ready  character [7:0], last_char
//
// one number at a time: accept, shift-add-3 conversion over every bit of the
// value, a skip state that drops leading zeros, then a minus sign when the
// value is negative and then the digit characters.
// synchronous reset returns the sequencer to idle; no payload is cleared.
// out_ready low holds the current character; no input is taken until the
// last character of the number has been taken.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii
  import sid_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            character,
  output logic                  last_char
);

  sid_cmd_t cmd;
  sid_sts_t sts;

  sid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sid_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk       (clk),
    .value     (value),
    .cmd       (cmd),
    .sts       (sts),
    .character (character),
    .last_char (last_char)
  );

endmodule
